[rtl/frn_pkg.sv]
// shared constants, types and opcodes of the focus ring navigator
package frn_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W        = 64;
   localparam int ENTRY_W     = ID_W + 1;

   localparam int OP_W     = 3;
   localparam int REQ_BITS = OP_W + ID_W + 4;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 3 + IDX_W + ID_W + CNT_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_BEGIN_LOAD  = 3'd0,
      OP_APPEND      = 3'd1,
      OP_FINISH_LOAD = 3'd2,
      OP_FOCUS_ID    = 3'd3,
      OP_NEXT        = 3'd4,
      OP_PREVIOUS    = 3'd5,
      OP_INVALIDATE  = 3'd6,
      OP_NOP         = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

[rtl/focus_ring_navigator_unit.sv]
// top level of the focus ring navigator: command sequencer over the entry table
//
// usage:
//   requests enter on req_ (tvalid/tready/tdata), one at a time; each request gives
//   exactly one response on rsp_ (tvalid/tready/tdata).
//   csr_ writes the wrap_navigation bit; write it only while no request is in flight.
//   begin_load, append, invalidate and no-op go from ST_START straight to ST_DONE.
//   finish_load, focus_id, next and previous walk the entry table through the single
//   ram read port, one entry per cycle, stopping at the first hit.
//   req_tready is high only while the sequencer is idle, so one request is worked on
//   at a time; the next request may be accepted while a response still waits.
//   when the receiver stalls, the response holds in the output register and the
//   following command finishes its work but holds its response until rsp_tready.
//   reset empties the table, drops focus and the remembered id and sets wrap on;
//   the table ram itself is not cleared, only entries below the count are read.
module focus_ring_navigator_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // operation, element_id, visible, enabled, focusable, reveals_hidden, zero pad
   input  logic [frn_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // success, overflow, has_focus, focus_index, focused_id, entry_count, zero pad
   output logic [frn_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [0:0]                csr_wdata
);
   import frn_pkg::*;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic               elig_req_ff, elig_req_in;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               focus_valid_ff, focus_valid_in;
   logic [IDX_W-1:0]   focus_ptr_ff, focus_ptr_in;
   logic [ID_W-1:0]    focus_id_ff, focus_id_in;
   logic               retained_valid_ff, retained_valid_in;
   logic [ID_W-1:0]    retained_key_ff, retained_key_in;
   logic               wrap_ff, wrap_in;

   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   steps_ff, steps_in;
   logic               down_ff, down_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [ID_W-1:0]    key_ff, key_in;
   logic               first_found_ff, first_found_in;
   logic [IDX_W-1:0]   first_idx_ff, first_idx_in;
   logic [ID_W-1:0]    first_id_ff, first_id_in;

   logic               success_ff, success_in;
   logic               overflow_ff, overflow_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic               rd_elig;
   logic [ID_W-1:0]    rd_id;
   logic               need_key;
   logic               hit;
   logic [CNT_W-1:0]   fp_ext;
   logic [CNT_W-1:0]   fp_up;
   logic [CNT_W-1:0]   ptr_up;

   frn_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign wr_data  = {elig_req_ff, id_ff};
   assign rd_elig  = rd_data[ID_W];
   assign rd_id    = rd_data[ID_W-1:0];
   assign need_key = (op_ff == OP_FOCUS_ID) ||
                     ((op_ff == OP_FINISH_LOAD) && retained_valid_ff);
   assign hit      = rd_valid_ff && rd_elig && (!need_key || (rd_id == key_ff));
   assign fp_ext   = {{(CNT_W-IDX_W){1'b0}}, focus_ptr_ff};
   assign fp_up    = fp_ext + 1'b1;
   assign ptr_up   = {{(CNT_W-IDX_W){1'b0}}, ptr_ff} + 1'b1;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      id_in             = id_ff;
      elig_req_in       = elig_req_ff;
      count_in          = count_ff;
      focus_valid_in    = focus_valid_ff;
      focus_ptr_in      = focus_ptr_ff;
      focus_id_in       = focus_id_ff;
      retained_valid_in = retained_valid_ff;
      retained_key_in   = retained_key_ff;
      wrap_in           = wrap_ff;
      ptr_in            = ptr_ff;
      steps_in          = steps_ff;
      down_in           = down_ff;
      rd_valid_in       = 1'b0;
      rd_idx_in         = rd_idx_ff;
      key_in            = key_ff;
      first_found_in    = first_found_ff;
      first_idx_in      = first_idx_ff;
      first_id_in       = first_id_ff;
      success_in        = success_ff;
      overflow_in       = overflow_ff;
      rsp_tvalid_in     = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      wr_en             = 1'b0;

      if (csr_valid) begin
         wrap_in = csr_wdata[0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in       = op_type'(req_tdata[OP_W-1:0]);
               id_in       = req_tdata[OP_W +: ID_W];
               elig_req_in = req_tdata[OP_W+ID_W] && req_tdata[OP_W+ID_W+1] &&
                             req_tdata[OP_W+ID_W+2] && !req_tdata[OP_W+ID_W+3];
               success_in  = 1'b0;
               overflow_in = 1'b0;
               state_in    = ST_START;
            end
         end

         ST_START: begin
            state_in       = ST_SCAN;
            ptr_in         = '0;
            steps_in       = count_ff;
            down_in        = 1'b0;
            first_found_in = 1'b0;
            key_in         = id_ff;
            unique case (op_ff)
               OP_BEGIN_LOAD: begin
                  retained_valid_in = focus_valid_ff;
                  if (focus_valid_ff) begin
                     retained_key_in = focus_id_ff;
                  end
                  count_in       = '0;
                  focus_valid_in = 1'b0;
                  focus_ptr_in   = '0;
                  focus_id_in    = '0;
                  success_in     = 1'b1;
                  state_in       = ST_DONE;
               end
               OP_APPEND: begin
                  if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                     wr_en      = 1'b1;
                     count_in   = count_ff + 1'b1;
                     success_in = 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
                  state_in = ST_DONE;
               end
               OP_FINISH_LOAD: begin
                  // focus drops first, the remembered id is matched during the walk
                  focus_valid_in = 1'b0;
                  focus_ptr_in   = '0;
                  focus_id_in    = '0;
                  key_in         = retained_key_ff;
               end
               OP_FOCUS_ID: begin
               end
               OP_NEXT: begin
                  if (count_ff == '0) begin
                     state_in = ST_DONE;
                  end else if (focus_valid_ff) begin
                     ptr_in   = (fp_up == count_ff) ? '0 : fp_up[IDX_W-1:0];
                     steps_in = wrap_ff ? count_ff - 1'b1 : count_ff - 1'b1 - fp_ext;
                  end
               end
               OP_PREVIOUS: begin
                  down_in = 1'b1;
                  if (count_ff == '0) begin
                     state_in = ST_DONE;
                  end else if (focus_valid_ff) begin
                     ptr_in   = (focus_ptr_ff == '0) ? IDX_W'(count_ff - 1'b1)
                                                     : focus_ptr_ff - 1'b1;
                     steps_in = wrap_ff ? count_ff - 1'b1 : fp_ext;
                  end else begin
                     ptr_in = IDX_W'(count_ff - 1'b1);
                  end
               end
               OP_INVALIDATE: begin
                  count_in       = '0;
                  focus_valid_in = 1'b0;
                  focus_ptr_in   = '0;
                  focus_id_in    = '0;
                  success_in     = 1'b1;
                  state_in       = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_SCAN: begin
            // the entry read last cycle is checked while the next address goes out
            if (rd_valid_ff && rd_elig && !first_found_ff) begin
               first_found_in = 1'b1;
               first_idx_in   = rd_idx_ff;
               first_id_in    = rd_id;
            end
            if (hit) begin
               focus_valid_in = 1'b1;
               focus_ptr_in   = rd_idx_ff;
               focus_id_in    = rd_id;
               success_in     = 1'b1;
               if (op_ff == OP_FINISH_LOAD) begin
                  retained_valid_in = 1'b0;
               end
               state_in = ST_DONE;
            end else if ((steps_ff == '0) && !rd_valid_ff) begin
               if (op_ff == OP_FINISH_LOAD) begin
                  retained_valid_in = 1'b0;
                  if (first_found_ff) begin
                     focus_valid_in = 1'b1;
                     focus_ptr_in   = first_idx_ff;
                     focus_id_in    = first_id_ff;
                     success_in     = 1'b1;
                  end
               end
               state_in = ST_DONE;
            end else if (steps_ff != '0) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = ptr_ff;
               steps_in    = steps_ff - 1'b1;
               if (down_ff) begin
                  ptr_in = (ptr_ff == '0) ? IDX_W'(count_ff - 1'b1) : ptr_ff - 1'b1;
               end else begin
                  ptr_in = (ptr_up == count_ff) ? '0 : ptr_up[IDX_W-1:0];
               end
            end
         end

         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = RSP_W'({count_ff,
                                       focus_valid_ff ? focus_id_ff : {ID_W{1'b0}},
                                       focus_valid_ff ? focus_ptr_ff : {IDX_W{1'b0}},
                                       focus_valid_ff,
                                       overflow_ff,
                                       success_ff});
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         count_ff          <= '0;
         focus_valid_ff    <= 1'b0;
         focus_ptr_ff      <= '0;
         focus_id_ff       <= '0;
         retained_valid_ff <= 1'b0;
         retained_key_ff   <= '0;
         wrap_ff           <= 1'b1;
         rd_valid_ff       <= 1'b0;
         rsp_tvalid_ff     <= 1'b0;
      end else begin
         state_ff          <= state_in;
         count_ff          <= count_in;
         focus_valid_ff    <= focus_valid_in;
         focus_ptr_ff      <= focus_ptr_in;
         focus_id_ff       <= focus_id_in;
         retained_valid_ff <= retained_valid_in;
         retained_key_ff   <= retained_key_in;
         wrap_ff           <= wrap_in;
         rd_valid_ff       <= rd_valid_in;
         rsp_tvalid_ff     <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      id_ff          <= id_in;
      elig_req_ff    <= elig_req_in;
      ptr_ff         <= ptr_in;
      steps_ff       <= steps_in;
      down_ff        <= down_in;
      rd_idx_ff      <= rd_idx_in;
      key_ff         <= key_in;
      first_found_ff <= first_found_in;
      first_idx_ff   <= first_idx_in;
      first_id_ff    <= first_id_in;
      success_ff     <= success_in;
      overflow_ff    <= overflow_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule

[rtl/frn_ram.sv]
// generic single write port ram with registered read
module frn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/tb_top.sv]
// self-checking testbench of the focus ring navigator: directed and random command streams
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import frn_pkg::*;

   localparam logic [3:0] ELIGIBLE_ATTR = 4'b0111;  // {reveals_hidden, focusable, enabled, visible}
   localparam int ITEM_TARGET   = 1750;
   localparam int PHASE_ITEMS   = 300;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LEN     = 300;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [ID_W-1:0]  id;
      logic [IDX_W-1:0] index;
      logic             has_focus;
      logic             overflow;
      logic             success;
   } focus_result_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // operation, element_id, visible, enabled, focusable, reveals_hidden, zero pad
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // success, overflow, has_focus, focus_index, focused_id, entry_count, zero pad
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [0:0]       csr_wdata  = 1'b1;

   // predicted block state
   logic [ID_W-1:0] tbl_id [MAX_ENTRIES];
   bit              tbl_ok [MAX_ENTRIES];
   int              tbl_count  = 0;
   bit              cur_valid  = 1'b0;
   int              cur_ptr    = 0;
   bit              kept_valid = 1'b0;
   logic [ID_W-1:0] kept_id    = '0;
   bit              wrap_on    = 1'b1;

   focus_result_type expected_results[$];
   logic [ID_W-1:0]  id_history[$];
   int               fault_count  = 0;
   int               items_sent   = 0;
   int               next_gap     = 0;
   int               stall_cycles = 0;
   bit               burst_mode   = 1'b0;

   focus_ring_navigator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("focus_ring_navigator_unit regression: fail");
      $finish;
   end

   function automatic int draw_gap();
      if (burst_mode) return 0;
      return $urandom_range(0, 15);
   endfunction

   // first eligible entry in [lo, hi), upward or downward
   function automatic bit scan_eligible(input int lo, input int hi, input bit down,
                                        output int where);
      int i;
      where = 0;
      if (hi > tbl_count) hi = tbl_count;
      if (lo >= hi) return 1'b0;
      if (!down) begin
         for (i = lo; i < hi; i++) begin
            if (tbl_ok[i]) begin
               where = i;
               return 1'b1;
            end
         end
      end else begin
         for (i = hi - 1; i >= lo; i--) begin
            if (tbl_ok[i]) begin
               where = i;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic bit find_focusable_id(input logic [ID_W-1:0] id, output int where);
      int i;
      where = 0;
      for (i = 0; i < tbl_count; i++) begin
         if (tbl_ok[i] && tbl_id[i] == id) begin
            where = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic focus_result_type predict_focus(input op_type op,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [3:0] attr);
      focus_result_type r;
      int               where;
      bit               hit;
      r = '0;
      where = 0;
      hit = 1'b0;
      case (op)
         OP_BEGIN_LOAD: begin
            kept_valid = 1'b0;
            if (cur_valid && cur_ptr < tbl_count) begin
               kept_valid = 1'b1;
               kept_id = tbl_id[cur_ptr];
            end
            tbl_count = 0;
            cur_valid = 1'b0;
            cur_ptr = 0;
            r.success = 1'b1;
         end
         OP_APPEND: begin
            if (tbl_count < MAX_ENTRIES) begin
               tbl_id[tbl_count] = id;
               tbl_ok[tbl_count] = (attr == ELIGIBLE_ATTR);
               tbl_count++;
               r.success = 1'b1;
            end else begin
               r.overflow = 1'b1;
            end
         end
         OP_FINISH_LOAD: begin
            cur_valid = 1'b0;
            cur_ptr = 0;
            if (kept_valid) hit = find_focusable_id(kept_id, where);
            if (!hit) hit = scan_eligible(0, tbl_count, 1'b0, where);
            if (hit) begin
               cur_valid = 1'b1;
               cur_ptr = where;
               r.success = 1'b1;
            end
            kept_valid = 1'b0;
         end
         OP_FOCUS_ID: begin
            if (find_focusable_id(id, where)) begin
               cur_valid = 1'b1;
               cur_ptr = where;
               r.success = 1'b1;
            end
         end
         OP_NEXT, OP_PREVIOUS: begin
            if (tbl_count != 0) begin
               if (!cur_valid) begin
                  hit = scan_eligible(0, tbl_count, op == OP_PREVIOUS, where);
               end else if (op == OP_NEXT) begin
                  hit = scan_eligible(cur_ptr + 1, tbl_count, 1'b0, where);
                  if (!hit && wrap_on) hit = scan_eligible(0, cur_ptr, 1'b0, where);
               end else begin
                  hit = scan_eligible(0, cur_ptr, 1'b1, where);
                  if (!hit && wrap_on) hit = scan_eligible(cur_ptr + 1, tbl_count, 1'b1, where);
               end
               if (hit) begin
                  cur_valid = 1'b1;
                  cur_ptr = where;
                  r.success = 1'b1;
               end
            end
         end
         OP_INVALIDATE: begin
            tbl_count = 0;
            cur_valid = 1'b0;
            cur_ptr = 0;
            r.success = 1'b1;
         end
         default: ;
      endcase
      r.has_focus = cur_valid && cur_ptr < tbl_count;
      if (r.has_focus) begin
         r.index = cur_ptr[IDX_W-1:0];
         r.id = tbl_id[cur_ptr];
      end
      r.count = tbl_count[CNT_W-1:0];
      return r;
   endfunction

   // valid stays high into the next request when its drawn gap is zero
   task automatic send_request(input op_type op, input logic [ID_W-1:0] id,
                               input logic [3:0] attr);
      repeat (next_gap) @(posedge clock);
      req_tdata <= {1'b0, attr, id, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.insert(expected_results.size(), predict_focus(op, id, attr));
      items_sent++;
      if (op == OP_APPEND) begin
         id_history.insert(id_history.size(), id);
         if (id_history.size() > MAX_ENTRIES) void'(id_history.pop_front());
      end
      next_gap = draw_gap();
      if (next_gap != 0) req_tvalid <= 1'b0;
   endtask

   task automatic wait_all_results();
      if (next_gap == 0) req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      next_gap = draw_gap();
   endtask

   // only called once the block is idle
   task automatic write_wrap(input logic value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      wrap_on = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(0, 5);
      if (r < 2 && id_history.size() != 0)
         return id_history[$urandom_range(0, id_history.size() - 1)];
      if (r == 2) return ($urandom_range(0, 1) != 0) ? '1 : '0;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [3:0] pick_attr();
      if ($urandom_range(0, 9) < 6) return ELIGIBLE_ATTR;
      return 4'($urandom_range(0, 15));
   endfunction

   initial begin : result_monitor
      focus_result_type got;
      focus_result_type want;
      int               wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = focus_result_type'(rsp_tdata[RSP_BITS-1:0]);
            if (expected_results.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected response: %h", rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("mismatch exp: ok=%b ovf=%b foc=%b idx=%0d id=%h cnt=%0d",
                              want.success, want.overflow, want.has_focus, want.index,
                              want.id, want.count);
                     $display("         got: ok=%b ovf=%b foc=%b idx=%0d id=%h cnt=%0d",
                              got.success, got.overflow, got.has_focus, got.index,
                              got.id, got.count);
                  end
               end
            end
            wait_left = draw_gap();
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_tready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_reset_state();
      send_request(OP_NEXT, '0, ELIGIBLE_ATTR);
      send_request(OP_PREVIOUS, '1, ELIGIBLE_ATTR);
      send_request(OP_FINISH_LOAD, '0, 4'b0000);
      send_request(OP_NOP, '1, 4'b1111);
   endtask

   task automatic test_directed_load();
      send_request(OP_BEGIN_LOAD, '0, 4'b0000);
      send_request(OP_APPEND, '0, ELIGIBLE_ATTR);
      send_request(OP_APPEND, '1, ELIGIBLE_ATTR);
      // one failing attribute each: hidden, disabled, not focusable, reveals hidden
      send_request(OP_APPEND, 64'h0000_0000_0000_00a1, 4'b0110);
      send_request(OP_APPEND, 64'h0000_0000_0000_00a2, 4'b0101);
      send_request(OP_APPEND, 64'h0000_0000_0000_00a3, 4'b0011);
      send_request(OP_APPEND, 64'h0000_0000_0000_00a4, 4'b1111);
      send_request(OP_APPEND, 64'h0123_4567_89ab_cdef, ELIGIBLE_ATTR);
      send_request(OP_FINISH_LOAD, '0, 4'b0000);
      send_request(OP_FOCUS_ID, '1, 4'b0000);
      send_request(OP_FOCUS_ID, 64'h0000_0000_0000_00a1, 4'b0000);
      send_request(OP_FOCUS_ID, 64'hdead_0000_0000_beef, 4'b0000);
      send_request(OP_NEXT, '0, 4'b0000);
      send_request(OP_NEXT, '0, 4'b0000);
      send_request(OP_PREVIOUS, '0, 4'b0000);
      // focus sits on the last entry, its id is remembered across the reload
      send_request(OP_BEGIN_LOAD, '0, 4'b0000);
      send_request(OP_APPEND, 64'h5555_5555_5555_5555, ELIGIBLE_ATTR);
      send_request(OP_APPEND, 64'h0123_4567_89ab_cdef, ELIGIBLE_ATTR);
      send_request(OP_FINISH_LOAD, '0, 4'b0000);
      send_request(OP_INVALIDATE, '0, 4'b0000);
      send_request(OP_APPEND, 64'haaaa_aaaa_aaaa_aaaa, ELIGIBLE_ATTR);
      send_request(OP_NEXT, '0, 4'b0000);
      send_request(OP_NOP, '0, 4'b0000);
      wait_all_results();
   endtask

   task automatic test_no_wrap();
      write_wrap(1'b0);
      send_request(OP_BEGIN_LOAD, '0, 4'b0000);
      send_request(OP_APPEND, 64'h1111, ELIGIBLE_ATTR);
      send_request(OP_APPEND, 64'h2222, 4'b1000);
      send_request(OP_APPEND, 64'h3333, ELIGIBLE_ATTR);
      send_request(OP_FINISH_LOAD, '0, 4'b0000);
      send_request(OP_PREVIOUS, '0, 4'b0000);
      send_request(OP_NEXT, '0, 4'b0000);
      send_request(OP_NEXT, '0, 4'b0000);
      // previous without focus takes the last eligible entry
      send_request(OP_INVALIDATE, '0, 4'b0000);
      send_request(OP_APPEND, 64'h4444, ELIGIBLE_ATTR);
      send_request(OP_APPEND, 64'h5555, ELIGIBLE_ATTR);
      send_request(OP_PREVIOUS, '0, 4'b0000);
      wait_all_results();
      write_wrap(1'b1);
   endtask

   task automatic test_table_full();
      int i;
      send_request(OP_BEGIN_LOAD, '0, 4'b0000);
      for (i = 0; i < MAX_ENTRIES + 2; i++)
         send_request(OP_APPEND, pick_id(),
                      (i == 0 || i == MAX_ENTRIES - 1) ? ELIGIBLE_ATTR : pick_attr());
      send_request(OP_FINISH_LOAD, '0, 4'b0000);
      send_request(OP_PREVIOUS, '0, 4'b0000);
      send_request(OP_NEXT, '0, 4'b0000);
      send_request(OP_FOCUS_ID, tbl_id[MAX_ENTRIES-1], 4'b0000);
      send_request(OP_PREVIOUS, '0, 4'b0000);
      wait_all_results();
   endtask

   task automatic test_input_stall();
      burst_mode = 1'b1;
      stall_cycles = STALL_LEN;
      repeat (12) send_request(op_type'($urandom_range(0, 7)), pick_id(), pick_attr());
      wait_all_results();
      burst_mode = 1'b0;
   endtask

   task automatic run_session();
      int r;
      int n;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 8))
            send_request(op_type'($urandom_range(0, 7)), pick_id(),
                         4'($urandom_range(0, 15)));
         return;
      end
      if ($urandom_range(0, 7) != 0)
         send_request(OP_BEGIN_LOAD, pick_id(), 4'($urandom_range(0, 15)));
      r = $urandom_range(0, 31);
      if (r == 0) n = $urandom_range(MAX_ENTRIES - 4, MAX_ENTRIES + 2);
      else if (r < 3) n = $urandom_range(20, MAX_ENTRIES - 5);
      else n = $urandom_range(0, 10);
      repeat (n) send_request(OP_APPEND, pick_id(), pick_attr());
      if ($urandom_range(0, 9) != 0)
         send_request(OP_FINISH_LOAD, pick_id(), 4'($urandom_range(0, 15)));
      repeat ($urandom_range(2, 14)) begin
         r = $urandom_range(0, 9);
         if (r < 3) begin
            send_request(OP_NEXT, pick_id(), 4'($urandom_range(0, 15)));
         end else if (r < 6) begin
            send_request(OP_PREVIOUS, pick_id(), 4'($urandom_range(0, 15)));
         end else if (r < 8) begin
            if (tbl_count != 0 && $urandom_range(0, 3) != 0)
               send_request(OP_FOCUS_ID, tbl_id[$urandom_range(0, tbl_count - 1)], 4'b0000);
            else
               send_request(OP_FOCUS_ID, pick_id(), 4'($urandom_range(0, 15)));
         end else if (r == 8) begin
            send_request(OP_APPEND, pick_id(), pick_attr());
         end else begin
            send_request(op_type'($urandom_range(0, 7)), pick_id(),
                         4'($urandom_range(0, 15)));
         end
      end
   endtask

   task automatic test_random_sessions();
      int stop_at;
      int phase_at;
      int phase;
      stop_at = ITEM_TARGET;
      phase_at = items_sent + PHASE_ITEMS;
      phase = 0;
      while (items_sent < stop_at) begin
         if (items_sent >= phase_at) begin
            wait_all_results();
            write_wrap(phase[0]);
            burst_mode = ($urandom_range(0, 3) == 0);
            phase++;
            phase_at += PHASE_ITEMS;
         end
         run_session();
      end
      burst_mode = 1'b0;
   endtask

   initial begin : main_sequence
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_load();
      test_no_wrap();
      test_table_full();
      test_input_stall();
      test_random_sessions();
      wait_all_results();
      if (fault_count == 0) begin
         $display("focus_ring_navigator_unit regression: pass");
      end else begin
         $display("focus_ring_navigator_unit regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/frn_pkg.sv
rtl/frn_ram.sv
rtl/focus_ring_navigator_unit.sv
dv/tb_top.sv
